// ===== hw/rtl/mbic_pkg.sv =====
// Shared constants, codes and types for the multiband image correlation block.
`timescale 1ns / 1ps

package mbic_pkg;

    localparam int MAX_WIDTH   = 64;
    localparam int MAX_HEIGHT  = 64;
    localparam int MAX_BANDS   = 3;
    localparam int MAX_TAPS    = 9;

    localparam int PLANE_SIZE  = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_DEPTH = PLANE_SIZE * MAX_BANDS;
    localparam int STORE_AW    = 14;
    localparam int WEIGHT_N    = MAX_TAPS * MAX_BANDS;
    localparam int WIDX_W      = 5;
    localparam int PROD_W      = 25;
    localparam int ACC_W       = 30;

    typedef enum logic [1:0] {
        FUNC_LOAD_TAP    = 2'd0,
        FUNC_LOAD_SAMPLE = 2'd1,
        FUNC_COMPUTE     = 2'd2,
        FUNC_NONE        = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_BAND_COUNT   = 2'd2,
        CFG_TAP_COUNT    = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_FINISH
    } state_t;

    // control from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;
        logic valid;
    } mac_ctl_t;

endpackage

// ===== hw/rtl/mbic_in_if.sv =====
// Input channel: valid/ready handshake carrying one command word.
`timescale 1ns / 1ps

interface mbic_in_if;
    logic              valid;
    logic              ready;
    logic [1:0]        func;
    logic [3:0]        tap_index;
    logic signed [4:0] tap_dx;
    logic signed [4:0] tap_dy;
    logic [1:0]        band;
    logic signed [15:0] tap_weight;
    logic [5:0]        col;
    logic [5:0]        row;
    logic [7:0]        sample;

    modport source (
        output valid, func, tap_index, tap_dx, tap_dy, band, tap_weight, col, row, sample,
        input  ready
    );
    modport sink (
        input  valid, func, tap_index, tap_dx, tap_dy, band, tap_weight, col, row, sample,
        output ready
    );
endinterface

// ===== hw/rtl/mbic_out_if.sv =====
// Result channel: valid/ready handshake carrying one output pixel word.
`timescale 1ns / 1ps

interface mbic_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pixel_out;
    logic        saturated;

    modport source (
        output valid, pixel_out, saturated,
        input  ready
    );
    modport sink (
        input  valid, pixel_out, saturated,
        output ready
    );
endinterface

// ===== hw/rtl/multiband_image_correlation_relu.sv =====
// Top level: command decode, tap/weight tables, image RAM and the MAC sequencer.
`timescale 1ns / 1ps

// Multiband image correlation with rectification.
// item (sink): one command word per handshake. func selects a tap load (offset
//   and one band's Q7.8 weight), an image sample load, or an output request at
//   (col, row). Loads complete in the cycle they are accepted.
// result (source): one word (pixel_out, saturated) per output request.
// cfg_we/cfg_index/cfg_data: register writes; write them only while idle.
// An output request walks taps x bands through one shared multiplier, one
// image RAM read per cycle, then passes the drain and finish states; result
// valid rises once the finish state loads the output register (a request
// outside the image or with no taps or bands skips the walk), and the next
// command is taken back in idle. item.ready is low for the whole walk;
// loads are taken every cycle while idle.
// The result sits in an output register; a new command is taken while it
// waits. A second request finishes its walk and then holds until the earlier
// word is taken by the receiver.
// Reset sets width/height 64, one band, nine taps. The image, tap and weight
// stores are not cleared; each entry must be written before it is used.
module multiband_image_correlation_relu (
    input  logic              clk,
    input  logic              rst_n,
    mbic_in_if.sink           item,
    mbic_out_if.source        result,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);
    import mbic_pkg::*;

    state_t state_reg, state_next;

    logic [6:0] width_reg, height_reg;
    logic [1:0] bands_reg;
    logic [3:0] taps_reg;
    logic [6:0] w_eff, h_eff;
    logic [3:0] nt_eff;

    logic [9:0]  tap_offsets [MAX_TAPS];
    logic [15:0] tap_weights [WEIGHT_N];

    logic [5:0] col_reg, row_reg;
    logic [3:0] tap_reg;
    logic [1:0] band_reg;
    logic       drain_reg;

    logic              s1_valid_reg;
    logic [WIDX_W-1:0] s1_widx_reg;
    logic [WIDX_W-1:0] widx;

    logic              out_valid_reg;
    logic [15:0]       pixel_reg;
    logic              sat_reg;

    logic accept, req_accept, tap_we, sample_we;
    logic in_image, start_walk, last_step, issue_hit, out_load;
    logic signed [7:0] xq, yq;
    logic [STORE_AW-1:0] ram_raddr, ram_waddr;
    logic [7:0]  ram_rdata;
    logic [WIDX_W-1:0] load_widx;
    mac_ctl_t    mac_ctl;
    logic signed [ACC_W-1:0] acc;
    logic [20:0] acc_int;

    // effective sizes
    always_comb
    begin
        w_eff  = (width_reg == 7'd0) ? 7'd1 :
                 (width_reg > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : width_reg;
        h_eff  = (height_reg == 7'd0) ? 7'd1 :
                 (height_reg > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : height_reg;
        nt_eff = (taps_reg > 4'(MAX_TAPS)) ? 4'(MAX_TAPS) : taps_reg;
    end

    assign accept     = item.valid && item.ready;
    assign req_accept = accept && (func_t'(item.func) == FUNC_COMPUTE);
    assign tap_we     = accept && (func_t'(item.func) == FUNC_LOAD_TAP)
                        && (item.tap_index < 4'(MAX_TAPS)) && (item.band < 2'(MAX_BANDS));
    assign sample_we  = accept && (func_t'(item.func) == FUNC_LOAD_SAMPLE)
                        && (item.band < 2'(MAX_BANDS));
    assign load_widx  = WIDX_W'({item.tap_index, 1'b0}) + WIDX_W'(item.tap_index)
                        + WIDX_W'(item.band);
    assign ram_waddr  = {item.band, item.row, item.col};

    assign in_image   = ({1'b0, item.col} < w_eff) && ({1'b0, item.row} < h_eff);
    assign start_walk = in_image && (nt_eff != 4'd0) && (bands_reg != 2'd0);

    // neighbor of the current tap
    assign xq = $signed({2'b00, col_reg}) + 8'($signed(tap_offsets[tap_reg][4:0]));
    assign yq = $signed({2'b00, row_reg}) + 8'($signed(tap_offsets[tap_reg][9:5]));
    assign issue_hit = !xq[7] && (xq[6:0] < w_eff) && !yq[7] && (yq[6:0] < h_eff);
    assign ram_raddr = {band_reg, yq[5:0], xq[5:0]};
    assign widx      = WIDX_W'({tap_reg, 1'b0}) + WIDX_W'(tap_reg) + WIDX_W'(band_reg);
    assign last_step = (tap_reg == nt_eff - 4'd1) && (band_reg == bands_reg - 2'd1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_accept)
                begin
                    state_next = start_walk ? ST_RUN : ST_DRAIN;
                end
            end
            ST_RUN:
            begin
                if (last_step)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain_reg)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        item.ready    = 1'b0;
        out_load      = 1'b0;
        mac_ctl.clear = 1'b0;
        mac_ctl.valid = s1_valid_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item.ready    = 1'b1;
                mac_ctl.clear = req_accept;
            end
            ST_RUN:
            begin
            end
            ST_DRAIN:
            begin
            end
            ST_FINISH:
            begin
                out_load = !out_valid_reg || result.ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            width_reg  <= 7'(MAX_WIDTH);
            height_reg <= 7'(MAX_HEIGHT);
            bands_reg  <= 2'd1;
            taps_reg   <= 4'(MAX_TAPS);
            tap_reg    <= '0;
            band_reg   <= '0;
            drain_reg  <= 1'b0;
            s1_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                    CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                    CFG_BAND_COUNT:   bands_reg  <= cfg_data[1:0];
                    CFG_TAP_COUNT:    taps_reg   <= cfg_data[3:0];
                    default: ;
                endcase
            end

            s1_valid_reg <= (state_reg == ST_RUN) && issue_hit;

            if (req_accept)
            begin
                tap_reg   <= '0;
                band_reg  <= '0;
                drain_reg <= 1'b0;
            end
            else if (state_reg == ST_RUN)
            begin
                if (band_reg == bands_reg - 2'd1)
                begin
                    band_reg <= '0;
                    tap_reg  <= tap_reg + 4'd1;
                end
                else
                begin
                    band_reg <= band_reg + 2'd1;
                end
            end
            else if (state_reg == ST_DRAIN)
            begin
                drain_reg <= 1'b1;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        s1_widx_reg <= widx;
        if (req_accept)
        begin
            col_reg <= item.col;
            row_reg <= item.row;
        end
        if (tap_we)
        begin
            tap_offsets[item.tap_index] <= {item.tap_dy, item.tap_dx};
            tap_weights[load_widx]      <= item.tap_weight;
        end
        if (out_load)
        begin
            pixel_reg <= (|acc_int[20:16]) ? 16'hFFFF : acc_int[15:0];
            sat_reg   <= |acc_int[20:16];
        end
    end

    // rectify, then drop the fraction
    assign acc_int = acc[ACC_W-1] ? 21'd0 : acc[28:8];

    mbic_ram #(
        .WIDTH (8),
        .DEPTH (STORE_DEPTH)
    ) u_image_ram (
        .clk   (clk),
        .we    (sample_we),
        .waddr (ram_waddr),
        .wdata (item.sample),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    mbic_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mac_ctl),
        .sample (ram_rdata),
        .weight (tap_weights[s1_widx_reg]),
        .acc    (acc)
    );

    assign result.valid     = out_valid_reg;
    assign result.pixel_out = pixel_reg;
    assign result.saturated = sat_reg;

endmodule

// ===== hw/rtl/mbic_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mbic_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/mbic_mac.sv =====
// Shared multiply-accumulate unit: registered product, then signed accumulate.
`timescale 1ns / 1ps

module mbic_mac (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mbic_pkg::mac_ctl_t             ctl,
    input  logic [7:0]                     sample,
    input  logic [15:0]                    weight,
    output logic signed [mbic_pkg::ACC_W-1:0] acc
);
    import mbic_pkg::*;

    logic                     prod_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_reg;

    assign prod_next = $signed({1'b0, sample}) * $signed(weight);

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else if (ctl.clear)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctl.valid;
            if (prod_valid_reg)
            begin
                acc_reg <= acc_reg + ACC_W'(prod_reg);
            end
        end
    end

    assign acc = acc_reg;

endmodule
